FILE: design/fed_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fed_pkg: shared types and constants for the field energy diagnostics block
// Accumulator widths, result width, register indexes and controller commands.
// ----------------------------------------------------------------------------
package fed_pkg;

    localparam int SUM_BITS  = 56;
    localparam int HEAT_BITS = 53;
    localparam int PEAK_BITS = 33;
    localparam int OUT_BITS  = 63;
    localparam int VOL_BITS  = 32;
    localparam int DAMP_BITS = 32;
    localparam int MOP_BITS  = 32;
    // scaled value: a 56-bit sum times a Q0.32 volume, shifted down by 32
    localparam int SC_BITS   = SUM_BITS + 1;

    localparam logic [PEAK_BITS-1:0] PEAK_MAX = '1;

    // configuration register indexes, decoded from paddr[2]
    localparam logic REG_CELL_VOLUME   = 1'b0;
    localparam logic REG_SPONGE_ENABLE = 1'b1;

    // scaling sequence: two half-word multiplies for each of three values
    localparam int SCALE_MULS = 6;
    localparam int CNT_BITS   = $clog2(SCALE_MULS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_ACC,
        S_SCALE,
        S_LOAD
    } t_state;

    typedef enum logic [1:0] {
        SRC_MAG,
        SRC_ELEC,
        SRC_PEAK
    } t_src;

    typedef struct packed {
        logic cap;
        logic sum;
        logic acc;
        logic mul_en;
        t_src mul_src;
        logic mul_hi;
        logic fold_en;
        t_src fold_src;
        logic fold_hi;
        logic load;
    } t_cmd;

endpackage
`default_nettype wire

FILE: design/fed_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fed_if: streaming channels of the field energy diagnostics block
// Cell input channel and diagnostics result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface fed_in_if #(
    parameter int FIELD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [FIELD_BITS-1:0] mag_x;
    logic signed [FIELD_BITS-1:0] mag_y;
    logic signed [FIELD_BITS-1:0] mag_z;
    logic signed [FIELD_BITS-1:0] elec_x;
    logic signed [FIELD_BITS-1:0] elec_y;
    logic signed [FIELD_BITS-1:0] elec_z;
    logic [31:0]                  cell_damped;
    logic                         last_cell;

    modport source (
        output valid, mag_x, mag_y, mag_z, elec_x, elec_y, elec_z, cell_damped, last_cell,
        input  ready
    );
    modport sink (
        input  valid, mag_x, mag_y, mag_z, elec_x, elec_y, elec_z, cell_damped, last_cell,
        output ready
    );
    modport mon (
        input valid, ready, mag_x, mag_y, mag_z, elec_x, elec_y, elec_z, cell_damped,
        last_cell
    );
endinterface

interface fed_out_if;
    logic        valid;
    logic        ready;
    logic [62:0] magnetic_energy;
    logic [62:0] electric_energy;
    logic [62:0] total_energy;
    logic [62:0] ohmic_heat;
    logic [62:0] peak_e_dot_b;

    modport source (
        output valid, magnetic_energy, electric_energy, total_energy, ohmic_heat,
               peak_e_dot_b,
        input  ready
    );
    modport sink (
        input  valid, magnetic_energy, electric_energy, total_energy, ohmic_heat,
               peak_e_dot_b,
        output ready
    );
    modport mon (
        input valid, ready, magnetic_energy, electric_energy, total_energy, ohmic_heat,
              peak_e_dot_b
    );
endinterface
`default_nettype wire

FILE: design/fed_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fed_ctrl: controller of the field energy diagnostics block
// Sequences capture, sum, accumulate, volume scaling and result load.
// ----------------------------------------------------------------------------
module fed_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_last_cell,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output fed_pkg::t_cmd o_cmd
);
    import fed_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic [CNT_BITS-1:0] r_cnt;
    logic [CNT_BITS-1:0] n_cnt;
    logic [CNT_BITS-1:0] n_fold_idx;
    logic                r_last;
    logic                r_out_valid;
    t_cmd                n_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (n_cmd.cap) begin
                r_last <= i_last_cell;
            end
            if (n_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_cmd      = '0;
        n_fold_idx = r_cnt - CNT_BITS'(1);
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_cmd.cap = 1'b1;
                    n_state   = S_SUM;
                end
            end
            S_SUM: begin
                n_cmd.sum = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                n_cmd.acc = 1'b1;
                n_cnt     = '0;
                n_state   = r_last ? S_SCALE : S_IDLE;
            end
            S_SCALE: begin
                // multiply at step k, fold that product in at step k+1
                if (r_cnt < CNT_BITS'(SCALE_MULS)) begin
                    n_cmd.mul_en  = 1'b1;
                    n_cmd.mul_src = t_src'(r_cnt[CNT_BITS-1:1]);
                    n_cmd.mul_hi  = r_cnt[0];
                end
                if (r_cnt != '0) begin
                    n_cmd.fold_en  = 1'b1;
                    n_cmd.fold_src = t_src'(n_fold_idx[CNT_BITS-1:1]);
                    n_cmd.fold_hi  = n_fold_idx[0];
                end
                n_cnt = r_cnt + CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(SCALE_MULS)) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    n_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd       = n_cmd;
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

FILE: design/fed_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fed_dpath: datapath of the field energy diagnostics block
// Field products, pass accumulators, shared volume multiplier, result register.
// ----------------------------------------------------------------------------
module fed_dpath #(
    parameter int FIELD_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  fed_pkg::t_cmd                   i_cmd,
    input  logic signed [FIELD_BITS-1:0]    i_mag_x,
    input  logic signed [FIELD_BITS-1:0]    i_mag_y,
    input  logic signed [FIELD_BITS-1:0]    i_mag_z,
    input  logic signed [FIELD_BITS-1:0]    i_elec_x,
    input  logic signed [FIELD_BITS-1:0]    i_elec_y,
    input  logic signed [FIELD_BITS-1:0]    i_elec_z,
    input  logic [fed_pkg::DAMP_BITS-1:0]   i_cell_damped,
    input  logic [fed_pkg::VOL_BITS-1:0]    i_cell_volume,
    input  logic                            i_sponge_enable,
    output logic [fed_pkg::OUT_BITS-1:0]    o_magnetic_energy,
    output logic [fed_pkg::OUT_BITS-1:0]    o_electric_energy,
    output logic [fed_pkg::OUT_BITS-1:0]    o_total_energy,
    output logic [fed_pkg::OUT_BITS-1:0]    o_ohmic_heat,
    output logic [fed_pkg::OUT_BITS-1:0]    o_peak_e_dot_b
);
    import fed_pkg::*;

    localparam int PROD_W = 2 * FIELD_BITS;
    localparam int DOT_W  = PROD_W + 1;
    localparam int CMP_W  = (DOT_W > PEAK_BITS) ? DOT_W : PEAK_BITS;

    // capture stage: one product per multiplier
    logic signed [PROD_W-1:0] r_bxx, r_byy, r_bzz;
    logic signed [PROD_W-1:0] r_exx, r_eyy, r_ezz;
    logic signed [PROD_W-1:0] r_bex, r_bey, r_bez;
    logic [DAMP_BITS-1:0]     r_damp;

    // sum stage
    logic [PROD_W-1:0]    r_sq_b;
    logic [PROD_W-1:0]    r_sq_e;
    logic [PEAK_BITS-1:0] r_dot_abs;
    logic [DAMP_BITS-1:0] r_damp_s;
    logic [PROD_W-1:0]    n_sq_b;
    logic [PROD_W-1:0]    n_sq_e;
    logic signed [DOT_W-1:0] n_dot;
    logic [DOT_W-1:0]     n_abs;
    logic [CMP_W-1:0]     n_abs_ext;
    logic [PEAK_BITS-1:0] n_dot_clip;

    // pass accumulators
    logic [SUM_BITS-1:0]  r_mag_sum;
    logic [SUM_BITS-1:0]  r_elec_sum;
    logic [HEAT_BITS-1:0] r_heat_sum;
    logic [PEAK_BITS-1:0] r_peak_dot;
    logic [SUM_BITS:0]    n_mag;
    logic [SUM_BITS:0]    n_elec;
    logic [HEAT_BITS:0]   n_heat;

    // volume scaling
    logic [63:0]          n_full;
    logic [MOP_BITS-1:0]  n_mop;
    logic [63:0]          r_mprod;
    logic [31:0]          r_part;
    logic [SC_BITS-1:0]   n_folded;
    logic [SC_BITS-1:0]   r_sc_mag;
    logic [SC_BITS-1:0]   r_sc_elec;
    logic [SC_BITS-1:0]   r_sc_peak;

    // result register
    logic [OUT_BITS-1:0]  r_out_mag;
    logic [OUT_BITS-1:0]  r_out_elec;
    logic [OUT_BITS-1:0]  r_out_total;
    logic [OUT_BITS-1:0]  r_out_heat;
    logic [OUT_BITS-1:0]  r_out_peak;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_bxx  <= i_mag_x * i_mag_x;
            r_byy  <= i_mag_y * i_mag_y;
            r_bzz  <= i_mag_z * i_mag_z;
            r_exx  <= i_elec_x * i_elec_x;
            r_eyy  <= i_elec_y * i_elec_y;
            r_ezz  <= i_elec_z * i_elec_z;
            r_bex  <= i_mag_x * i_elec_x;
            r_bey  <= i_mag_y * i_elec_y;
            r_bez  <= i_mag_z * i_elec_z;
            // only cells taken while the sponge is on add heat
            r_damp <= i_sponge_enable ? i_cell_damped : '0;
        end
    end

    // squares are non-negative and three of them stay below 2^PROD_W
    always_comb begin
        n_sq_b     = $unsigned(r_bxx) + $unsigned(r_byy) + $unsigned(r_bzz);
        n_sq_e     = $unsigned(r_exx) + $unsigned(r_eyy) + $unsigned(r_ezz);
        n_dot      = DOT_W'(r_bex) + DOT_W'(r_bey) + DOT_W'(r_bez);
        n_abs      = n_dot[DOT_W-1] ? $unsigned(-n_dot) : $unsigned(n_dot);
        n_abs_ext  = CMP_W'(n_abs);
        n_dot_clip = (n_abs_ext > CMP_W'(PEAK_MAX)) ? PEAK_MAX : n_abs_ext[PEAK_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            r_sq_b    <= n_sq_b;
            r_sq_e    <= n_sq_e;
            r_dot_abs <= n_dot_clip;
            r_damp_s  <= r_damp;
        end
    end

    // saturating adds: accumulators never exceed their all-ones value
    always_comb begin
        n_mag  = {1'b0, r_mag_sum} + (SUM_BITS + 1)'(r_sq_b);
        n_elec = {1'b0, r_elec_sum} + (SUM_BITS + 1)'(r_sq_e);
        n_heat = {1'b0, r_heat_sum} + (HEAT_BITS + 1)'(r_damp_s);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag_sum  <= '0;
            r_elec_sum <= '0;
            r_heat_sum <= '0;
            r_peak_dot <= '0;
        end else if (i_cmd.load) begin
            r_mag_sum  <= '0;
            r_elec_sum <= '0;
            r_heat_sum <= '0;
            r_peak_dot <= '0;
        end else if (i_cmd.acc) begin
            r_mag_sum  <= n_mag[SUM_BITS] ? '1 : n_mag[SUM_BITS-1:0];
            r_elec_sum <= n_elec[SUM_BITS] ? '1 : n_elec[SUM_BITS-1:0];
            r_heat_sum <= n_heat[HEAT_BITS] ? '1 : n_heat[HEAT_BITS-1:0];
            if (r_dot_abs > r_peak_dot) begin
                r_peak_dot <= r_dot_abs;
            end
        end
    end

    // pick the half word for the shared 32x32 volume multiplier
    always_comb begin
        unique case (i_cmd.mul_src)
            SRC_MAG:  n_full = 64'(r_mag_sum);
            SRC_ELEC: n_full = 64'(r_elec_sum);
            SRC_PEAK: n_full = 64'(r_peak_dot);
            default:  n_full = '0;
        endcase
        n_mop    = i_cmd.mul_hi ? n_full[63:32] : n_full[31:0];
        n_folded = SC_BITS'(r_mprod + 64'(r_part));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_mprod <= 64'(n_mop) * 64'(i_cell_volume);
        end
        if (i_cmd.fold_en) begin
            if (!i_cmd.fold_hi) begin
                r_part <= r_mprod[63:32];
            end else begin
                unique case (i_cmd.fold_src)
                    SRC_MAG:  r_sc_mag  <= n_folded;
                    SRC_ELEC: r_sc_elec <= n_folded;
                    SRC_PEAK: r_sc_peak <= n_folded;
                    default:  r_sc_peak <= r_sc_peak;
                endcase
            end
        end
    end

    // scaled values stay far below 2^63, so the outputs need no clamp
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_mag   <= OUT_BITS'(r_sc_mag >> 1);
            r_out_elec  <= OUT_BITS'(r_sc_elec >> 1);
            r_out_total <= OUT_BITS'(r_sc_mag >> 1) + OUT_BITS'(r_sc_elec >> 1);
            r_out_heat  <= OUT_BITS'(r_heat_sum);
            r_out_peak  <= OUT_BITS'(r_sc_peak);
        end
    end

    assign o_magnetic_energy = r_out_mag;
    assign o_electric_energy = r_out_elec;
    assign o_total_energy    = r_out_total;
    assign o_ohmic_heat      = r_out_heat;
    assign o_peak_e_dot_b    = r_out_peak;

endmodule
`default_nettype wire

FILE: design/field_energy_diagnostics.sv
`default_nettype none
// ----------------------------------------------------------------------------
// field_energy_diagnostics: per-pass field energy and E dot B peak
// Accumulates |B|^2, |E|^2 and damped energy over a pass of grid cells and
// emits volume-scaled energies, heat and peak |E dot B| on the last cell.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            content
//  i_cell    in   valid/ready          B, E (signed Q4.12), damped energy, last
//  o_diag    out  valid/ready          energies, total, heat, peak E dot B
//  apb       in   psel/penable/pwrite  cell_volume @0x0, sponge_enable @0x4
//
//  A cell is captured into nine multipliers, summed in three-term sums, then
//  accumulated. The last cell of a pass then runs six half-word products on
//  the one shared 32x32 volume multiplier and loads the result register. Reset
//  is synchronous and clears the pass state and the configuration registers.
//  A stalled result waits in the output register while the next pass streams
//  in; only a second finished pass waits for it.
// ----------------------------------------------------------------------------
module field_energy_diagnostics #(
    parameter int FIELD_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fed_in_if.sink       i_cell,
    fed_out_if.source    o_diag,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import fed_pkg::*;

    logic [VOL_BITS-1:0] r_cell_volume;
    logic                r_sponge_enable;
    logic                n_cfg_wr;
    t_cmd                w_cmd;

    assign n_cfg_wr = psel && penable && pwrite;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_volume   <= '0;
            r_sponge_enable <= 1'b0;
        end else if (n_cfg_wr) begin
            unique case (paddr[2])
                REG_CELL_VOLUME:   r_cell_volume   <= pwdata;
                REG_SPONGE_ENABLE: r_sponge_enable <= pwdata[0];
                default:           r_cell_volume   <= r_cell_volume;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_CELL_VOLUME:   prdata = r_cell_volume;
            REG_SPONGE_ENABLE: prdata = {31'd0, r_sponge_enable};
            default:           prdata = '0;
        endcase
    end

    fed_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cell.valid),
        .i_last_cell (i_cell.last_cell),
        .o_in_ready  (i_cell.ready),
        .i_out_ready (o_diag.ready),
        .o_out_valid (o_diag.valid),
        .o_cmd       (w_cmd)
    );

    fed_dpath #(
        .FIELD_BITS (FIELD_BITS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_mag_x           (i_cell.mag_x),
        .i_mag_y           (i_cell.mag_y),
        .i_mag_z           (i_cell.mag_z),
        .i_elec_x          (i_cell.elec_x),
        .i_elec_y          (i_cell.elec_y),
        .i_elec_z          (i_cell.elec_z),
        .i_cell_damped     (i_cell.cell_damped),
        .i_cell_volume     (r_cell_volume),
        .i_sponge_enable   (r_sponge_enable),
        .o_magnetic_energy (o_diag.magnetic_energy),
        .o_electric_energy (o_diag.electric_energy),
        .o_total_energy    (o_diag.total_energy),
        .o_ohmic_heat      (o_diag.ohmic_heat),
        .o_peak_e_dot_b    (o_diag.peak_e_dot_b)
    );

endmodule
`default_nettype wire

FILE: design/fed_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fed_checker: port-level checks for the field energy diagnostics block
// Watches the cell and result channels of the top level over time.
// ----------------------------------------------------------------------------
module fed_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    fed_in_if.sink    i_cell,
    fed_out_if.source o_diag
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_diag.valid && !o_diag.ready |=> o_diag.valid && $stable(o_diag.total_energy)
            && $stable(o_diag.peak_e_dot_b))
        else $error("result changed while stalled");

    // total is the sum of both energies
    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_diag.valid |-> (64'(o_diag.magnetic_energy) + 64'(o_diag.electric_energy)
            == 64'(o_diag.total_energy)))
        else $error("total energy mismatch");

    // ready drops in the cycle after a cell is taken
    a_one_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cell.valid && i_cell.ready |=> !i_cell.ready)
        else $error("cell taken back to back");

    // scaled peak and magnetic energy stay within their value ranges
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_diag.valid |-> (o_diag.peak_e_dot_b[62:33] == '0)
            && (o_diag.magnetic_energy[62:56] == '0))
        else $error("result out of range");

endmodule

bind field_energy_diagnostics fed_checker u_fed_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_cell  (i_cell),
    .o_diag  (o_diag)
);
`default_nettype wire

FILE: tb/field_energy_diagnostics_tb.sv
// ----------------------------------------------------------------------------
// field_energy_diagnostics_tb: self-checking bench for the field energy unit
// Streams grid cells through the cell channel, programs volume and sponge over
// APB between cells, and checks every pass result against a local predictor.
// ----------------------------------------------------------------------------
module field_energy_diagnostics_tb;
    import fed_pkg::*;

    localparam int RAND_CELLS    = 700;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int END_CYCLES    = 20;
    localparam int PRINT_LIMIT   = 40;

    typedef struct {
        logic [15:0] mag_x;
        logic [15:0] mag_y;
        logic [15:0] mag_z;
        logic [15:0] elec_x;
        logic [15:0] elec_y;
        logic [15:0] elec_z;
        logic [31:0] damped;
        logic        last;
    } t_cell;

    typedef struct packed {
        logic [OUT_BITS-1:0] magnetic_energy;
        logic [OUT_BITS-1:0] electric_energy;
        logic [OUT_BITS-1:0] total_energy;
        logic [OUT_BITS-1:0] ohmic_heat;
        logic [OUT_BITS-1:0] peak_e_dot_b;
    } t_diag;

    typedef struct {
        bit           is_cfg;
        logic         cfg_idx;
        logic [31:0]  cfg_val;
        t_cell        cell_data;
        bit           typed;
        t_diag        want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    fed_in_if #(.FIELD_BITS(16)) cell_if ();
    fed_out_if                   diag_if ();

    field_energy_diagnostics #(
        .FIELD_BITS(16)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cell  (cell_if),
        .o_diag  (diag_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state and register copies
    logic [SUM_BITS-1:0]  mag_acc  = '0;
    logic [SUM_BITS-1:0]  elec_acc = '0;
    logic [HEAT_BITS-1:0] heat_acc = '0;
    logic [PEAK_BITS-1:0] peak_acc = '0;
    logic [VOL_BITS-1:0]  vol_q    = '0;
    logic                 sponge_q = 1'b0;

    t_diag pending_diag[$];
    t_row  dir_rows[$];
    t_diag oldest;
    int    mismatches = 0;
    int    cells_sent = 0;
    bit    no_stall   = 1'b0;
    bit    hold_req   = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
                                            input int bits);
        logic [64:0] s;
        logic [64:0] lim;
        lim = (65'd1 << bits) - 65'd1;
        s = {1'b0, a} + {1'b0, b};
        return (s > lim) ? lim[63:0] : s[63:0];
    endfunction

    // floor(a * v / 2^32)
    function automatic logic [56:0] vol_scale(input logic [55:0] a, input logic [31:0] v);
        logic [87:0] p;
        p = {32'd0, a} * {56'd0, v};
        return {1'b0, p[87:32]};
    endfunction

    function automatic bit accumulate_cell(input t_cell c, output t_diag d);
        longint      bx, by, bz, ex, ey, ez, dot;
        logic [63:0] mag2, elec2, mag_dot, tmp;
        logic [62:0] me, ee;
        bx = longint'($signed(c.mag_x));
        by = longint'($signed(c.mag_y));
        bz = longint'($signed(c.mag_z));
        ex = longint'($signed(c.elec_x));
        ey = longint'($signed(c.elec_y));
        ez = longint'($signed(c.elec_z));
        mag2  = bx * bx + by * by + bz * bz;
        elec2 = ex * ex + ey * ey + ez * ez;
        tmp = sat_add({8'd0, mag_acc}, mag2, SUM_BITS);
        mag_acc = tmp[SUM_BITS-1:0];
        tmp = sat_add({8'd0, elec_acc}, elec2, SUM_BITS);
        elec_acc = tmp[SUM_BITS-1:0];
        if (sponge_q) begin
            tmp = sat_add({11'd0, heat_acc}, {32'd0, c.damped}, HEAT_BITS);
            heat_acc = tmp[HEAT_BITS-1:0];
        end
        dot = bx * ex + by * ey + bz * ez;
        mag_dot = (dot < 0) ? -dot : dot;
        if (mag_dot > {31'd0, PEAK_MAX}) mag_dot = {31'd0, PEAK_MAX};
        if (mag_dot[PEAK_BITS-1:0] > peak_acc) peak_acc = mag_dot[PEAK_BITS-1:0];
        d = '0;
        if (!c.last) return 1'b0;
        me = vol_scale(mag_acc, vol_q) >> 1;
        ee = vol_scale(elec_acc, vol_q) >> 1;
        tmp = sat_add({1'b0, me}, {1'b0, ee}, OUT_BITS);
        d.magnetic_energy = me;
        d.electric_energy = ee;
        d.total_energy    = tmp[OUT_BITS-1:0];
        d.ohmic_heat      = heat_acc;
        d.peak_e_dot_b    = vol_scale({23'd0, peak_acc}, vol_q);
        // end of pass: clear the running sums
        mag_acc  = '0;
        elec_acc = '0;
        heat_acc = '0;
        peak_acc = '0;
        return 1'b1;
    endfunction

    function automatic t_cell mk_cell(input logic [15:0] bx, by, bz, ex, ey, ez,
                                      input logic [31:0] damped, input logic last);
        t_cell c;
        c.mag_x  = bx;
        c.mag_y  = by;
        c.mag_z  = bz;
        c.elec_x = ex;
        c.elec_y = ey;
        c.elec_z = ez;
        c.damped = damped;
        c.last   = last;
        return c;
    endfunction

    function automatic t_diag mk_diag(input logic [62:0] me, ee, te, oh, pk);
        t_diag d;
        d.magnetic_energy = me;
        d.electric_energy = ee;
        d.total_energy    = te;
        d.ohmic_heat      = oh;
        d.peak_e_dot_b    = pk;
        return d;
    endfunction

    function automatic void add_cell(input t_cell c, input bit typed, input t_diag want);
        t_row r;
        r.is_cfg    = 1'b0;
        r.cfg_idx   = REG_CELL_VOLUME;
        r.cfg_val   = '0;
        r.cell_data = c;
        r.typed     = typed;
        r.want      = want;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_cfg(input logic idx, input logic [31:0] val);
        t_row r;
        r.is_cfg    = 1'b1;
        r.cfg_idx   = idx;
        r.cfg_val   = val;
        r.cell_data = mk_cell('0, '0, '0, '0, '0, '0, '0, 1'b0);
        r.typed     = 1'b0;
        r.want      = '0;
        dir_rows.push_back(r);
    endfunction

    function automatic logic [15:0] rand_field();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return {10'd0, r[5:0]};
            4: return {10'h3FF, r[5:0]};
            default: return r[15:0];
        endcase
    endfunction

    function automatic t_cell rand_cell(input logic last);
        logic [31:0] damped;
        case ($urandom_range(3))
            0: damped = 32'hFFFF_FFFF;
            1: damped = 32'h0;
            default: damped = $urandom;
        endcase
        return mk_cell(rand_field(), rand_field(), rand_field(),
                       rand_field(), rand_field(), rand_field(), damped, last);
    endfunction

    function automatic logic [31:0] pick_volume();
        case ($urandom_range(5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h1;
            3: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [62:0] got,
                                   input logic [62:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch: %s got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [62:0] got,
                               input logic [62:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    task automatic send_cell(input t_cell c, input bit typed, input t_diag want);
        t_diag d;
        while (!no_stall && $urandom_range(99) < 14) begin
            cell_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cell_if.valid       <= 1'b1;
        cell_if.mag_x       <= c.mag_x;
        cell_if.mag_y       <= c.mag_y;
        cell_if.mag_z       <= c.mag_z;
        cell_if.elec_x      <= c.elec_x;
        cell_if.elec_y      <= c.elec_y;
        cell_if.elec_z      <= c.elec_z;
        cell_if.cell_damped <= c.damped;
        cell_if.last_cell   <= c.last;
        @(posedge i_clk);
        while (!cell_if.ready) @(posedge i_clk);
        if (accumulate_cell(c, d)) pending_diag.push_back(typed ? want : d);
        cells_sent++;
    endtask

    // drop valid, drain every pending result, then let the pipeline empty
    task automatic quiesce();
        cell_if.valid <= 1'b0;
        while (pending_diag.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_CELL_VOLUME) vol_q = val;
        else sponge_q = val[0];
        @(posedge i_clk);
    endtask

    // result side: random stalls, one long hold-off when requested
    initial begin : result_sink
        bit held;
        int n;
        held = 1'b0;
        diag_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !held) begin
                held = 1'b1;
                diag_if.ready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++) @(posedge i_clk);
            end
            diag_if.ready <= no_stall || ($urandom_range(99) >= 14);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && diag_if.valid && diag_if.ready) begin
            if (pending_diag.size() == 0) begin
                report_mismatch("result with nothing pending", diag_if.magnetic_energy, '0);
            end else begin
                oldest = pending_diag.pop_front();
                check_field("magnetic_energy", diag_if.magnetic_energy,
                            oldest.magnetic_energy);
                check_field("electric_energy", diag_if.electric_energy,
                            oldest.electric_energy);
                check_field("total_energy", diag_if.total_energy, oldest.total_energy);
                check_field("ohmic_heat", diag_if.ohmic_heat, oldest.ohmic_heat);
                check_field("peak_e_dot_b", diag_if.peak_e_dot_b, oldest.peak_e_dot_b);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((cell_if.valid && cell_if.ready) || (diag_if.valid && diag_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int    passes;
        int    len;
        int    k;
        int    phase;
        int    dir_cells;
        t_diag zero_diag;

        i_rst_n             <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        cell_if.valid       <= 1'b0;
        cell_if.mag_x       <= '0;
        cell_if.mag_y       <= '0;
        cell_if.mag_z       <= '0;
        cell_if.elec_x      <= '0;
        cell_if.elec_y      <= '0;
        cell_if.elec_z      <= '0;
        cell_if.cell_damped <= '0;
        cell_if.last_cell   <= 1'b0;
        zero_diag = '0;

        // volume zero after reset: every result is zero, heat too with the sponge off
        add_cell(mk_cell('0, '0, '0, '0, '0, '0, '0, 1'b1), 1'b1, zero_diag);
        add_cell(mk_cell(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                         32'hFFFF_FFFF, 1'b1), 1'b1, zero_diag);
        // volume one half: energies are a quarter of the sums, peak a half
        add_cfg(REG_CELL_VOLUME, 32'h8000_0000);
        add_cfg(REG_SPONGE_ENABLE, 32'h1);
        add_cell(mk_cell(16'h8000, 16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h8000,
                         32'hFFFF_FFFF, 1'b1), 1'b1,
                 mk_diag(63'd1 << 28, 63'd3 << 28, 63'd1 << 30, 63'hFFFF_FFFF,
                         63'd1 << 29));
        // full volume, extremes of both signs, negative dot product
        add_cfg(REG_CELL_VOLUME, 32'hFFFF_FFFF);
        add_cell(mk_cell(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                         32'hFFFF_FFFF, 1'b0), 1'b0, zero_diag);
        add_cell(mk_cell(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                         32'hFFFF_FFFF, 1'b0), 1'b0, zero_diag);
        add_cell(mk_cell(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000,
                         32'h0, 1'b1), 1'b0, zero_diag);
        // sponge switched off and volume changed in the middle of a pass
        add_cell(mk_cell(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                         32'h00FF_00FF, 1'b0), 1'b0, zero_diag);
        add_cfg(REG_SPONGE_ENABLE, 32'h0);
        add_cell(mk_cell(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                         32'hFF00_FF00, 1'b0), 1'b0, zero_diag);
        add_cfg(REG_CELL_VOLUME, 32'h1);
        add_cell(mk_cell(16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF,
                         32'h1, 1'b1), 1'b0, zero_diag);
        // zero volume with the sponge on: only the heat survives
        add_cfg(REG_CELL_VOLUME, 32'h0);
        add_cfg(REG_SPONGE_ENABLE, 32'h1);
        add_cell(mk_cell(16'h1234, 16'hEDCB, 16'h7FFF, 16'h8000, 16'h0F0F, 16'hF0F0,
                         32'hDEAD_BEEF, 1'b1), 1'b1,
                 mk_diag('0, '0, '0, 63'hDEAD_BEEF, '0));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                quiesce();
                write_reg(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
            end else begin
                send_cell(dir_rows[i].cell_data, dir_rows[i].typed, dir_rows[i].want);
            end
        end
        dir_cells = cells_sent;

        phase = 0;
        while (cells_sent < dir_cells + RAND_CELLS) begin
            quiesce();
            write_reg(REG_CELL_VOLUME, pick_volume());
            if ($urandom_range(1)) write_reg(REG_SPONGE_ENABLE, $urandom_range(1));
            no_stall = (phase == 2);
            // short passes while the result side is held off fill the block
            if (phase == 4) hold_req = 1'b1;
            passes = $urandom_range(2, 8);
            repeat (passes) begin
                if (phase == 4 || $urandom_range(9) != 0) len = $urandom_range(1, 8);
                else len = $urandom_range(9, 40);
                for (k = 0; k < len; k++) begin
                    if (k == len - 1 && len > 1 && $urandom_range(7) == 0) begin
                        quiesce();
                        write_reg($urandom_range(1) ? REG_SPONGE_ENABLE : REG_CELL_VOLUME,
                                  $urandom_range(1) ? pick_volume() : 32'h1);
                    end
                    send_cell(rand_cell(k == len - 1), 1'b0, zero_diag);
                end
            end
            phase++;
        end

        cell_if.valid <= 1'b0;
        no_stall = 1'b0;
        while (pending_diag.size() != 0) @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/fed_pkg.sv
design/fed_if.sv
design/fed_ctrl.sv
design/fed_dpath.sv
design/field_energy_diagnostics.sv
design/fed_checker.sv
tb/field_energy_diagnostics_tb.sv
